/* sv/modbus_rtu_command_framer_defines.svh */
// Assertion macros shared by the framer RTL.
`ifndef MODBUS_RTU_COMMAND_FRAMER_DEFINES_SVH
`define MODBUS_RTU_COMMAND_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define MRCF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MRCF_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRCF_ASSERT(lbl, clk, rst, prop, msg)
`define MRCF_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

/* sv/mrcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mrcf_pkg;

   localparam logic [1:0] FUNC_SEARCH   = 2'd0;
   localparam logic [1:0] FUNC_SET_ADDR = 2'd1;
   localparam logic [1:0] FUNC_SET_MASK = 2'd2;
   localparam logic [1:0] FUNC_UNUSED   = 2'd3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
   localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;
   localparam logic [7:0] WRITE_BYTE_COUNT  = 8'h02;
   localparam logic [7:0] REG_ADDR          = 8'h00;
   localparam logic [7:0] REG_MASK          = 8'h03;
   localparam logic [7:0] REG_SEARCH        = 8'h01;
   localparam logic [7:0] REG_COUNT         = 8'h01;

   localparam logic [3:0] SEARCH_LAST_IDX = 4'd5;
   localparam logic [3:0] WRITE_LAST_IDX  = 4'd8;

   typedef enum logic [1:0] {
      KIND_SEARCH,
      KIND_SET_ADDR,
      KIND_SET_MASK
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BODY,
      ST_CRC_LO,
      ST_CRC_HI
   } state_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] body_byte(input kind_type kind, input logic [3:0] idx,
                                            input logic [7:0] value);
      logic [7:0] b;
      b = 8'h00;
      if (kind == KIND_SEARCH) begin
         unique case (idx)
            4'd0:    b = value;
            4'd1:    b = FC_READ_HOLDING;
            4'd3:    b = REG_SEARCH;
            4'd5:    b = REG_COUNT;
            default: b = 8'h00;
         endcase
      end else begin
         unique case (idx)
            4'd1:    b = FC_WRITE_MULTIPLE;
            4'd3:    b = (kind == KIND_SET_ADDR) ? REG_ADDR : REG_MASK;
            4'd5:    b = REG_COUNT;
            4'd6:    b = WRITE_BYTE_COUNT;
            4'd8:    b = value;
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

`default_nettype wire

/* sv/mrcf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrcf_front
   import mrcf_pkg::*;
(
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,
   input  wire q_status_type q_status,
   output logic              q_push,
   output cmd_type           q_cmd
);

   logic [1:0] func;

   assign func       = req_tdata[1:0];
   assign req_tready = !q_status.full;

   // unused command code is consumed without queuing
   always_comb begin
      q_cmd.value = req_tdata[9:2];
      q_cmd.kind  = KIND_SEARCH;
      q_push      = 1'b0;
      unique case (func)
         FUNC_SEARCH: begin
            q_cmd.kind = KIND_SEARCH;
            q_push     = req_tvalid && req_tready;
         end
         FUNC_SET_ADDR: begin
            q_cmd.kind = KIND_SET_ADDR;
            q_push     = req_tvalid && req_tready;
         end
         FUNC_SET_MASK: begin
            q_cmd.kind = KIND_SET_MASK;
            q_push     = req_tvalid && req_tready;
         end
         FUNC_UNUSED: begin
            q_push = 1'b0;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/mrcf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrcf_queue
   import mrcf_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign head_cmd         = mem_ff[rd_ptr_ff];
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* sv/mrcf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrcf_back
   import mrcf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire q_status_type q_status,
   input  wire cmd_type      q_cmd,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   state_type   state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  value_ff, value_in;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        advance;
   logic [7:0]  body;
   logic [3:0]  last_idx;

   assign advance   = !valid_ff || rsp_tready;
   assign body      = body_byte(kind_ff, idx_ff, value_ff);
   assign last_idx  = (kind_ff == KIND_SEARCH) ? SEARCH_LAST_IDX : WRITE_LAST_IDX;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               q_pop    = 1'b1;
               kind_in  = q_cmd.kind;
               value_in = q_cmd.value;
               idx_in   = '0;
               crc_in   = CRC_INIT;
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            if (advance) begin
               valid_in = 1'b1;
               data_in  = body;
               last_in  = 1'b0;
               crc_in   = crc_update(crc_ff, body);
               idx_in   = idx_ff + 1'b1;
               if (idx_ff == last_idx) begin
                  state_in = ST_CRC_LO;
               end
            end
         end
         ST_CRC_LO: begin
            if (advance) begin
               valid_in = 1'b1;
               data_in  = crc_ff[7:0];
               last_in  = 1'b0;
               state_in = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (advance) begin
               valid_in = 1'b1;
               data_in  = crc_ff[15:8];
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      crc_ff   <= crc_in;
      kind_ff  <= kind_in;
      value_ff <= value_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

/* sv/modbus_rtu_command_framer.sv */
// Modbus RTU command framer. Each accepted request (func, value) becomes one
// complete RTU frame on the response stream, one byte per transfer, closed by
// the CRC-16/Modbus checksum sent low byte first; tlast marks the CRC high
// byte. func 0 gives an 8-byte read of holding register 1 from slave value,
// func 1 and 2 give 11-byte writes at slave 0 of register 0 (address) or
// register 3 (netmask); func 3 is accepted and produces nothing. Requests
// are queued (QUEUE_DEPTH deep) ahead of a byte sequencer that emits one byte
// per cycle while the response side does not stall and folds each byte into
// the CRC in the same cycle; between frames it passes through an idle state
// to fetch the next request from the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_command_framer_defines.svh"

module modbus_rtu_command_framer
   import mrcf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [1:0] func, [9:2] value, rest zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] frame_byte
   output logic             rsp_tlast
);

   q_status_type q_status;
   cmd_type      push_cmd;
   cmd_type      head_cmd;
   logic         q_push;
   logic         q_pop;

   mrcf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   mrcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   mrcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `MRCF_ASSERT(a_no_overflow, clock, reset, !(q_push && q_status.full), "queue overflow")
   `MRCF_ASSERT(a_no_underflow, clock, reset, q_pop |-> q_status.not_empty, "queue underflow")
   `MRCF_ASSERT(a_unused_dropped, clock, reset, (req_tvalid && req_tdata[1:0] == FUNC_UNUSED) |-> !q_push, "unused command queued")
   `MRCF_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

`default_nettype wire
